@@ src/erfq_pkg.sv @@
`timescale 1ns / 1ps

package erfq_pkg;

   localparam int WF = 30;

   localparam logic [30:0] ONE_Q  = 31'h4000_0000;
   localparam logic [63:0] HALF_Q = 64'h2000_0000;

   localparam logic [30:0] K_ERF   = 31'd1073741824;
   localparam logic [30:0] K_Q     = 31'd759250125;
   localparam logic [28:0] P_Q30   = 29'd351748265;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   localparam logic signed [32:0] A1_Q30 = 33'sd273621191;
   localparam logic signed [32:0] A2_Q30 = -33'sd305476044;
   localparam logic signed [32:0] A3_Q30 = 33'sd1526231383;
   localparam logic signed [32:0] A4_Q30 = -33'sd1560310108;
   localparam logic signed [32:0] A5_Q30 = 33'sd1139675401;

   localparam int EXP_TERMS = 12;
   localparam int POLY_STEPS = 5;

   typedef struct packed {
      logic neg;
      logic mode;
      logic big;
   } ctx_type;

   // coefficient added after Horner step n (the last step adds nothing)
   function automatic logic signed [32:0] poly_coef(input int n);
      logic signed [32:0] c;
      case (n)
         0: c = A4_Q30;
         1: c = A3_Q30;
         2: c = A2_Q30;
         3: c = A1_Q30;
         default: c = '0;
      endcase
      return c;
   endfunction

   // floor(2^32 / i), one less for i = 1
   function automatic logic [31:0] recip_const(input int i);
      logic [31:0] m;
      case (i)
         1: m = 32'd4294967295;
         2: m = 32'd2147483648;
         3: m = 32'd1431655765;
         4: m = 32'd1073741824;
         5: m = 32'd858993459;
         6: m = 32'd715827882;
         7: m = 32'd613566756;
         8: m = 32'd536870912;
         9: m = 32'd477218588;
         10: m = 32'd429496729;
         11: m = 32'd390451572;
         12: m = 32'd357913941;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

@@ src/erfq_recip.sv @@
`timescale 1ns / 1ps

module erfq_recip
   import erfq_pkg::*;
#(
   parameter int IN_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [15:0] in_arg,
   input  logic        in_mode,
   output logic        out_valid,
   output ctx_type     out_ctx,
   output logic [34:0] out_s,
   output logic [30:0] out_t
);

   localparam int XA_W  = 46 - IN_FRAC_BITS;
   localparam int DEN_W = (XA_W > 32) ? XA_W : 32;
   localparam int PW    = XA_W + 29;
   localparam int NDIV  = 31;

   // stage 1: |x| scaled to Q.30
   logic [15:0]     mag;
   logic [30:0]     kscale;
   logic [46:0]     kprod;
   logic            vld1_ff;
   logic [XA_W-1:0] xa_ff;
   ctx_type         ctx1_ff;

   assign mag    = in_arg[15] ? 16'(16'd0 - in_arg) : in_arg;
   assign kscale = in_mode ? K_Q : K_ERF;
   assign kprod  = 47'(mag) * 47'(kscale) + (47'(1) << (IN_FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) vld1_ff <= 1'b0;
      else if (en) vld1_ff <= in_valid;
      if (en) begin
         xa_ff        <= XA_W'(kprod >> IN_FRAC_BITS);
         ctx1_ff.neg  <= in_arg[15];
         ctx1_ff.mode <= in_mode;
         ctx1_ff.big  <= 1'b0;
      end
   end

   // stage 2: denominator, x^2, large-argument flag
   logic [PW-1:0]    pprod;
   logic [DEN_W-1:0] den_in;
   logic [30:0]      xq;
   logic [61:0]      sq;
   logic             big;

   assign pprod  = PW'(xa_ff) * PW'(P_Q30) + PW'(HALF_Q);
   assign den_in = DEN_W'(ONE_Q) + DEN_W'(pprod >> WF);
   assign xq     = 31'(xa_ff >> 2);
   assign sq     = 62'(xq) * 62'(xq) + (62'(1) << 25);
   assign big    = 64'(xa_ff) >= (64'd5 << WF);

   logic             vld_ff [NDIV+1];
   logic [DEN_W-1:0] den_ff [NDIV+1];
   logic [DEN_W-1:0] rem_ff [NDIV+1];
   logic [30:0]      q_ff   [NDIV+1];
   logic [34:0]      s_ff   [NDIV+1];
   ctx_type          ctx_ff [NDIV+1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else if (en) vld_ff[0] <= vld1_ff;
      if (en) begin
         den_ff[0] <= den_in;
         // top bits of the rounded numerator 2^60 + den/2
         rem_ff[0] <= DEN_W'(32'h2000_0000) + DEN_W'(den_in >> 32);
         q_ff[0]   <= '0;
         s_ff[0]   <= sq[60:26];
         ctx_ff[0] <= '{neg: ctx1_ff.neg, mode: ctx1_ff.mode, big: big};
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar j = 0; j < NDIV; j++) begin : g_div
      localparam int B = 30 - j;
      logic [DEN_W:0] r2;
      logic [DEN_W:0] diff;
      logic           ge;

      // numerator bit B equals den bit B+1
      assign r2   = {rem_ff[j], den_ff[j][B+1]};
      assign diff = r2 - {1'b0, den_ff[j]};
      assign ge   = r2 >= {1'b0, den_ff[j]};

      always_ff @(posedge clock) begin
         if (reset) vld_ff[j+1] <= 1'b0;
         else if (en) vld_ff[j+1] <= vld_ff[j];
         if (en) begin
            den_ff[j+1] <= den_ff[j];
            rem_ff[j+1] <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
            q_ff[j+1]   <= {q_ff[j][29:0], ge};
            s_ff[j+1]   <= s_ff[j];
            ctx_ff[j+1] <= ctx_ff[j];
         end
      end
   end

   assign out_valid = vld_ff[NDIV];
   assign out_ctx   = ctx_ff[NDIV];
   assign out_s     = s_ff[NDIV];
   assign out_t     = q_ff[NDIV];

endmodule

@@ src/erfq_poly.sv @@
`timescale 1ns / 1ps

module erfq_poly
   import erfq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  ctx_type     in_ctx,
   input  logic [34:0] in_s,
   input  logic [30:0] in_t,
   output logic        out_valid,
   output ctx_type     out_ctx,
   output logic [34:0] out_s,
   output logic [31:0] out_acc
);

   logic                src_vld [POLY_STEPS];
   logic signed [32:0]  src_acc [POLY_STEPS];
   logic [30:0]         src_t   [POLY_STEPS];
   logic [34:0]         src_s   [POLY_STEPS];
   ctx_type             src_ctx [POLY_STEPS];

   logic                m_vld_ff  [POLY_STEPS];
   logic [62:0]         m_prod_ff [POLY_STEPS];
   logic                m_neg_ff  [POLY_STEPS];
   logic [30:0]         m_t_ff    [POLY_STEPS];
   logic [34:0]         m_s_ff    [POLY_STEPS];
   ctx_type             m_ctx_ff  [POLY_STEPS];

   logic                a_vld_ff [POLY_STEPS];
   logic signed [32:0]  a_acc_ff [POLY_STEPS];
   logic [30:0]         a_t_ff   [POLY_STEPS];
   logic [34:0]         a_s_ff   [POLY_STEPS];
   ctx_type             a_ctx_ff [POLY_STEPS];

   for (genvar n = 0; n < POLY_STEPS; n++) begin : g_step
      logic [31:0]        mag;
      logic [32:0]        p;
      logic signed [32:0] pv;

      if (n == 0) begin : g_first
         assign src_vld[n] = in_valid;
         assign src_acc[n] = A5_Q30;
         assign src_t[n]   = in_t;
         assign src_s[n]   = in_s;
         assign src_ctx[n] = in_ctx;
      end else begin : g_next
         assign src_vld[n] = a_vld_ff[n-1];
         assign src_acc[n] = a_acc_ff[n-1];
         assign src_t[n]   = a_t_ff[n-1];
         assign src_s[n]   = a_s_ff[n-1];
         assign src_ctx[n] = a_ctx_ff[n-1];
      end

      // sign-magnitude product, rounded half up on the magnitude
      assign mag = src_acc[n][32] ? 32'(-src_acc[n]) : 32'(src_acc[n]);
      assign p   = 33'((m_prod_ff[n] + 63'(HALF_Q)) >> WF);
      assign pv  = m_neg_ff[n] ? -$signed(p) : $signed(p);

      always_ff @(posedge clock) begin
         if (reset) begin
            m_vld_ff[n] <= 1'b0;
            a_vld_ff[n] <= 1'b0;
         end else if (en) begin
            m_vld_ff[n] <= src_vld[n];
            a_vld_ff[n] <= m_vld_ff[n];
         end
         if (en) begin
            m_prod_ff[n] <= 63'(mag) * 63'(src_t[n]);
            m_neg_ff[n]  <= src_acc[n][32];
            m_t_ff[n]    <= src_t[n];
            m_s_ff[n]    <= src_s[n];
            m_ctx_ff[n]  <= src_ctx[n];
            a_acc_ff[n]  <= pv + poly_coef(n);
            a_t_ff[n]    <= m_t_ff[n];
            a_s_ff[n]    <= m_s_ff[n];
            a_ctx_ff[n]  <= m_ctx_ff[n];
         end
      end
   end

   assign out_valid = a_vld_ff[POLY_STEPS-1];
   assign out_ctx   = a_ctx_ff[POLY_STEPS-1];
   assign out_s     = a_s_ff[POLY_STEPS-1];
   assign out_acc   = a_acc_ff[POLY_STEPS-1][32] ? '0 : a_acc_ff[POLY_STEPS-1][31:0];

endmodule

@@ src/erfq_exp.sv @@
`timescale 1ns / 1ps

module erfq_exp
   import erfq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  ctx_type     in_ctx,
   input  logic [34:0] in_s,
   input  logic [31:0] in_acc,
   output logic        out_valid,
   output ctx_type     out_ctx,
   output logic [31:0] out_acc,
   output logic [30:0] out_e
);

   localparam int KBITS = 6;

   // s = k*ln2 + r, k by restoring division over KBITS stages
   logic        kd_vld_ff [KBITS];
   logic [35:0] kd_rem_ff [KBITS];
   logic [5:0]  kd_k_ff   [KBITS];
   logic [31:0] kd_acc_ff [KBITS];
   ctx_type     kd_ctx_ff [KBITS];

   for (genvar j = 0; j < KBITS; j++) begin : g_kdiv
      localparam int B = KBITS - 1 - j;
      logic        s_vld;
      logic [35:0] s_rem;
      logic [5:0]  s_k;
      logic [31:0] s_acc;
      ctx_type     s_ctx;
      logic [35:0] step;
      logic        ge;

      if (j == 0) begin : g_first
         assign s_vld = in_valid;
         assign s_rem = 36'(in_s);
         assign s_k   = '0;
         assign s_acc = in_acc;
         assign s_ctx = in_ctx;
      end else begin : g_next
         assign s_vld = kd_vld_ff[j-1];
         assign s_rem = kd_rem_ff[j-1];
         assign s_k   = kd_k_ff[j-1];
         assign s_acc = kd_acc_ff[j-1];
         assign s_ctx = kd_ctx_ff[j-1];
      end

      assign step = 36'(LN2_Q30) << B;
      assign ge   = s_rem >= step;

      always_ff @(posedge clock) begin
         if (reset) kd_vld_ff[j] <= 1'b0;
         else if (en) kd_vld_ff[j] <= s_vld;
         if (en) begin
            kd_rem_ff[j] <= ge ? s_rem - step : s_rem;
            kd_k_ff[j]   <= {s_k[4:0], ge};
            kd_acc_ff[j] <= s_acc;
            kd_ctx_ff[j] <= s_ctx;
         end
      end
   end

   // exp(-r) series, three stages per term: product, divide estimate, fix-up
   logic        pa_vld_ff [EXP_TERMS];
   logic [60:0] pa_ff     [EXP_TERMS];
   logic [29:0] pa_r_ff   [EXP_TERMS];
   logic [5:0]  pa_k_ff   [EXP_TERMS];
   logic [31:0] pa_acc_ff [EXP_TERMS];
   ctx_type     pa_ctx_ff [EXP_TERMS];

   logic        pb_vld_ff [EXP_TERMS];
   logic [63:0] pb_q_ff   [EXP_TERMS];
   logic [31:0] pb_x_ff   [EXP_TERMS];
   logic [29:0] pb_r_ff   [EXP_TERMS];
   logic [5:0]  pb_k_ff   [EXP_TERMS];
   logic [31:0] pb_acc_ff [EXP_TERMS];
   ctx_type     pb_ctx_ff [EXP_TERMS];

   logic        pc_vld_ff [EXP_TERMS];
   logic [30:0] pc_e_ff   [EXP_TERMS];
   logic [29:0] pc_r_ff   [EXP_TERMS];
   logic [5:0]  pc_k_ff   [EXP_TERMS];
   logic [31:0] pc_acc_ff [EXP_TERMS];
   ctx_type     pc_ctx_ff [EXP_TERMS];

   for (genvar n = 0; n < EXP_TERMS; n++) begin : g_term
      localparam int I = EXP_TERMS - n;
      localparam int HALF_I = I / 2;
      logic        s_vld;
      logic [29:0] s_r;
      logic [30:0] s_e;
      logic [5:0]  s_k;
      logic [31:0] s_acc;
      ctx_type     s_ctx;
      logic [30:0] term;
      logic [31:0] x;
      logic [31:0] qe;
      logic [31:0] resid;
      logic [31:0] q;

      if (n == 0) begin : g_first
         assign s_vld = kd_vld_ff[KBITS-1];
         assign s_r   = kd_rem_ff[KBITS-1][29:0];
         assign s_e   = ONE_Q;
         assign s_k   = kd_k_ff[KBITS-1];
         assign s_acc = kd_acc_ff[KBITS-1];
         assign s_ctx = kd_ctx_ff[KBITS-1];
      end else begin : g_next
         assign s_vld = pc_vld_ff[n-1];
         assign s_r   = pc_r_ff[n-1];
         assign s_e   = pc_e_ff[n-1];
         assign s_k   = pc_k_ff[n-1];
         assign s_acc = pc_acc_ff[n-1];
         assign s_ctx = pc_ctx_ff[n-1];
      end

      assign term  = 31'((pa_ff[n] + 61'(HALF_Q)) >> WF);
      assign x     = 32'(term) + 32'(HALF_I);
      // estimate is exact or one low
      assign qe    = pb_q_ff[n][63:32];
      assign resid = pb_x_ff[n] - 32'(qe * 32'(I));
      assign q     = (resid >= 32'(I)) ? qe + 32'd1 : qe;

      always_ff @(posedge clock) begin
         if (reset) begin
            pa_vld_ff[n] <= 1'b0;
            pb_vld_ff[n] <= 1'b0;
            pc_vld_ff[n] <= 1'b0;
         end else if (en) begin
            pa_vld_ff[n] <= s_vld;
            pb_vld_ff[n] <= pa_vld_ff[n];
            pc_vld_ff[n] <= pb_vld_ff[n];
         end
         if (en) begin
            pa_ff[n]     <= 61'(s_r) * 61'(s_e);
            pa_r_ff[n]   <= s_r;
            pa_k_ff[n]   <= s_k;
            pa_acc_ff[n] <= s_acc;
            pa_ctx_ff[n] <= s_ctx;

            pb_q_ff[n]   <= 64'(x) * 64'(recip_const(I));
            pb_x_ff[n]   <= x;
            pb_r_ff[n]   <= pa_r_ff[n];
            pb_k_ff[n]   <= pa_k_ff[n];
            pb_acc_ff[n] <= pa_acc_ff[n];
            pb_ctx_ff[n] <= pa_ctx_ff[n];

            pc_e_ff[n]   <= ONE_Q - 31'(q);
            pc_r_ff[n]   <= pb_r_ff[n];
            pc_k_ff[n]   <= pb_k_ff[n];
            pc_acc_ff[n] <= pb_acc_ff[n];
            pc_ctx_ff[n] <= pb_ctx_ff[n];
         end
      end
   end

   // 2^-k with rounding: ((2e >> k) + 1) >> 1
   logic [31:0] sh_tmp;
   logic [32:0] sh_rnd;
   logic        sh_vld_ff;
   logic [30:0] sh_e_ff;
   logic [31:0] sh_acc_ff;
   ctx_type     sh_ctx_ff;

   assign sh_tmp = {pc_e_ff[EXP_TERMS-1], 1'b0} >> pc_k_ff[EXP_TERMS-1];
   assign sh_rnd = (33'(sh_tmp) + 33'd1) >> 1;

   always_ff @(posedge clock) begin
      if (reset) sh_vld_ff <= 1'b0;
      else if (en) sh_vld_ff <= pc_vld_ff[EXP_TERMS-1];
      if (en) begin
         sh_e_ff   <= sh_rnd[30:0];
         sh_acc_ff <= pc_acc_ff[EXP_TERMS-1];
         sh_ctx_ff <= pc_ctx_ff[EXP_TERMS-1];
      end
   end

   assign out_valid = sh_vld_ff;
   assign out_ctx   = sh_ctx_ff;
   assign out_acc   = sh_acc_ff;
   assign out_e     = sh_e_ff;

endmodule

@@ src/erfq_tail.sv @@
`timescale 1ns / 1ps

module erfq_tail
   import erfq_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  ctx_type                  in_ctx,
   input  logic [31:0]              in_acc,
   input  logic [30:0]              in_e,
   output logic                     out_valid,
   output logic [OUT_FRAC_BITS+1:0] out_func
);

   localparam int OUT_W = OUT_FRAC_BITS + 2;

   // stage 1: P(t) * exp(-x^2)
   logic [30:0] eg;
   logic        t1_vld_ff;
   logic [62:0] t1_prod_ff;
   ctx_type     t1_ctx_ff;

   assign eg = in_ctx.big ? '0 : in_e;

   always_ff @(posedge clock) begin
      if (reset) t1_vld_ff <= 1'b0;
      else if (en) t1_vld_ff <= in_valid;
      if (en) begin
         t1_prod_ff <= 63'(in_acc) * 63'(eg);
         t1_ctx_ff  <= in_ctx;
      end
   end

   // stage 2: round, clamp to one, y = 1 - pe
   logic [32:0] pe_rnd;
   logic [30:0] pe_c;
   logic        t2_vld_ff;
   logic [30:0] t2_pe_ff;
   logic [30:0] t2_y_ff;
   ctx_type     t2_ctx_ff;

   assign pe_rnd = 33'((t1_prod_ff + 63'(HALF_Q)) >> WF);
   assign pe_c   = (pe_rnd > 33'(ONE_Q)) ? ONE_Q : pe_rnd[30:0];

   always_ff @(posedge clock) begin
      if (reset) t2_vld_ff <= 1'b0;
      else if (en) t2_vld_ff <= t1_vld_ff;
      if (en) begin
         t2_pe_ff  <= pe_c;
         t2_y_ff   <= ONE_Q - pe_c;
         t2_ctx_ff <= t1_ctx_ff;
      end
   end

   // stage 3: output format, result register
   logic [31:0]      lim;
   logic [31:0]      r0;
   logic [31:0]      r0c;
   logic [31:0]      twice;
   logic [31:0]      r1;
   logic [31:0]      r1c;
   logic [OUT_W-1:0] res;
   logic             vld_ff;
   logic [OUT_W-1:0] func_ff;

   assign lim   = 32'(1) << OUT_FRAC_BITS;
   assign r0    = (32'(t2_y_ff) + (32'(1) << (WF - 1 - OUT_FRAC_BITS))) >> (WF - OUT_FRAC_BITS);
   assign r0c   = (r0 > lim) ? lim : r0;
   // Q(x) = (1 - erf)/2: tail for x >= 0, 1 + erf|x| for negative x
   assign twice = t2_ctx_ff.neg ? 32'(ONE_Q) + 32'(t2_y_ff) : 32'(t2_pe_ff);
   assign r1    = (twice + (32'(1) << (WF - OUT_FRAC_BITS))) >> (WF + 1 - OUT_FRAC_BITS);
   assign r1c   = (r1 > lim) ? lim : r1;

   always_comb begin
      if (t2_ctx_ff.mode) res = OUT_W'(r1c);
      else if (t2_ctx_ff.neg) res = OUT_W'(32'd0 - r0c);
      else res = OUT_W'(r0c);
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (en) vld_ff <= t2_vld_ff;
      if (en) func_ff <= res;
   end

   assign out_valid = vld_ff;
   assign out_func  = func_ff;

endmodule

@@ src/erf_and_q_function_approx.sv @@
`timescale 1ns / 1ps

// channel | dir | fields
// req_    | in  | tdata[15:0] arg_value (signed Q4.12)
// rsp_    | out | tdata[17:0] func_value (signed Q1.16), upper bits zero
// csr_    | in  | wdata output_mode (0 erf, 1 Q)
//
// Fully pipelined: one request per cycle while rsp_tready does not stall the output.
// The pipeline holds the 31-stage reciprocal divider and the 12-term exp series
// (three stages per term).
// Synchronous reset clears the valid bits and sets output_mode to 1.
// A stall on rsp_tready freezes every stage; req_tready drops in the same cycle.

module erf_and_q_function_approx
   import erfq_pkg::*;
#(
   parameter int IN_FRAC_BITS  = 12,
   parameter int OUT_FRAC_BITS = 16,
   localparam int OUT_W   = OUT_FRAC_BITS + 2,
   localparam int TDATA_W = ((OUT_W + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,   // [15:0] arg_value
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // [OUT_W-1:0] func_value, rest zero
   input  logic               csr_wen,
   input  logic               csr_wdata
);

   logic en;
   logic mode_ff;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b1;
      else if (csr_wen) mode_ff <= csr_wdata;
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic        rc_vld;
   ctx_type     rc_ctx;
   logic [34:0] rc_s;
   logic [30:0] rc_t;

   erfq_recip #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_arg    (req_tdata),
      .in_mode   (mode_ff),
      .out_valid (rc_vld),
      .out_ctx   (rc_ctx),
      .out_s     (rc_s),
      .out_t     (rc_t)
   );

   logic        pl_vld;
   ctx_type     pl_ctx;
   logic [34:0] pl_s;
   logic [31:0] pl_acc;

   erfq_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rc_vld),
      .in_ctx    (rc_ctx),
      .in_s      (rc_s),
      .in_t      (rc_t),
      .out_valid (pl_vld),
      .out_ctx   (pl_ctx),
      .out_s     (pl_s),
      .out_acc   (pl_acc)
   );

   logic        ex_vld;
   ctx_type     ex_ctx;
   logic [31:0] ex_acc;
   logic [30:0] ex_e;

   erfq_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pl_vld),
      .in_ctx    (pl_ctx),
      .in_s      (pl_s),
      .in_acc    (pl_acc),
      .out_valid (ex_vld),
      .out_ctx   (ex_ctx),
      .out_acc   (ex_acc),
      .out_e     (ex_e)
   );

   logic [OUT_W-1:0] func_value;

   erfq_tail #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_tail (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ex_vld),
      .in_ctx    (ex_ctx),
      .in_acc    (ex_acc),
      .in_e      (ex_e),
      .out_valid (rsp_tvalid),
      .out_func  (func_value)
   );

   assign rsp_tdata = TDATA_W'(func_value);

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import erfq_pkg::*;

   localparam int LATENCY = 89;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_wen = 0;
   logic        csr_wdata = 0;

   erf_and_q_function_approx dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   // fixed-point erf / Q-function predictor, Q.30 internal
   class erf_scoreboard;
      bit             q_mode = 1'b1;
      logic [23:0]    pending[$];
      int             errors = 0;
      int             checked = 0;

      function logic signed [63:0] mul30(logic signed [63:0] a, logic [63:0] b);
         logic [63:0] m, p;
         m = (a < 0) ? -a : a;
         p = (m * b + HALF_Q) >> WF;
         return (a < 0) ? -$signed(p) : $signed(p);
      endfunction

      function logic [63:0] exp_of_neg(logic [63:0] s);
         logic [63:0] k, r, e, term;
         k = s / LN2_Q30;
         if (k >= 40) return 0;
         r = s - k * LN2_Q30;
         e = ONE_Q;
         for (int i = EXP_TERMS; i >= 1; i--) begin
            term = (r * e + HALF_Q) >> WF;
            term = (term + i / 2) / i;
            e = ONE_Q - term;
         end
         if (k > 0) e = (e + (64'd1 << (k - 1))) >> k;
         return e;
      endfunction

      function logic [23:0] func_of(logic [15:0] arg);
         logic [63:0] mag, xa, den, t, e, pe, y, r, res, xq, s, twice;
         logic signed [63:0] acc;
         bit neg;
         neg = arg[15];
         mag = neg ? 64'h10000 - arg : arg;
         xa = (mag * (q_mode ? K_Q : K_ERF) + 64'd2048) >> 12;
         den = ONE_Q + ((P_Q30 * xa + HALF_Q) >> WF);
         t = ((64'd1 << 60) + den / 2) / den;
         acc = A5_Q30;
         acc = mul30(acc, t) + A4_Q30;
         acc = mul30(acc, t) + A3_Q30;
         acc = mul30(acc, t) + A2_Q30;
         acc = mul30(acc, t) + A1_Q30;
         acc = mul30(acc, t);
         if (acc < 0) acc = 0;
         if (xa >= (64'd5 << WF)) begin
            e = 0;
         end else begin
            xq = xa >> 2;
            s = (xq * xq + (64'd1 << 25)) >> 26;
            e = exp_of_neg(s);
         end
         pe = (acc * e + HALF_Q) >> WF;
         if (pe > ONE_Q) pe = ONE_Q;
         y = ONE_Q - pe;
         if (!q_mode) begin
            r = (y + (64'd1 << 13)) >> 14;
            if (r > 65536) r = 65536;
            res = neg ? -r : r;
         end else begin
            twice = neg ? ONE_Q + y : pe;
            r = (twice + (64'd1 << 14)) >> 15;
            if (r > 65536) r = 65536;
            res = r;
         end
         return {6'b0, res[17:0]};
      endfunction

      function void note_request(logic [15:0] arg);
         pending.push_back(func_of(arg));
      endfunction

      function void check_response(logic [23:0] got);
         logic [23:0] want;
         if (pending.size() == 0) begin
            $error("func_value: unexpected response %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got[17:0] !== want[17:0]) begin
            $error("func_value: expected %h, actual %h", want[17:0], got[17:0]);
            errors++;
         end
         if (got[23:18] !== 6'b0) begin
            $error("tdata pad: expected 0, actual %h", got[23:18]);
            errors++;
         end
      endfunction
   endclass

   erf_scoreboard sb = new();
   logic [15:0] args[$];
   int idle_cycles = 0;
   bit hold_off = 0;
   bit drained = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || drained)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // sink: random stall per response, long hold-off on demand
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 1)) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) begin
            if (hold_off) break;
            @(posedge clock);
         end
      end
   end

   task automatic send_arg(input logic [15:0] arg, input bit busy);
      int gap;
      gap = busy ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= arg;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(arg);
   endtask

   task automatic drain_and_set(input bit mode);
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wen <= 1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_wen <= 0;
      sb.q_mode = mode;
   endtask

   task automatic run_phase(input int count, input bit pressure);
      logic [15:0] a;
      bit busy;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 5))
            0: a = 16'($urandom);
            1: a = 16'($urandom_range(0, 8191) - 4096);
            2: a = 16'(32'h7fff - $urandom_range(0, 15));
            3: a = 16'(32'h8000 + $urandom_range(0, 15));
            default: a = 16'($urandom_range(0, 24575) - 12288);
         endcase
         busy = (i % 200) < 60;
         if (pressure && i == 20) hold_off = 1;
         send_arg(a, busy);
      end
   endtask

   initial begin
      logic [15:0] corner[$];
      corner = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000,
         16'h8001, 16'h1000, 16'hf000, 16'h0800, 16'hf800, 16'h2000, 16'he000,
         16'h4000, 16'hc000, 16'h5000, 16'hb000, 16'h5555, 16'haaaa, 16'h0200};
      repeat (6) @(posedge clock);
      reset <= 0;
      // reset mode is Q
      foreach (corner[i]) send_arg(corner[i], 0);
      drain_and_set(0);
      foreach (corner[i]) send_arg(corner[i], 0);
      run_phase(450, 1);
      drain_and_set(1);
      run_phase(450, 0);
      drain_and_set(0);
      run_phase(250, 0);
      drain_and_set(1);
      run_phase(200, 0);
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      drained = 1;
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d erf/Q results over both modes, corners and random args,",
         sb.checked);
      $display("with random stalls on both sides and one long output back-pressure.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
